// File: src/twrtc_pkg.sv
// Shared types and constants for the three-wire RTC serial master.
`timescale 1ns / 1ps

package twrtc_pkg;

    localparam int unsigned BURST_BYTES_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_WRITE       = 2'd0;
    localparam logic [1:0] CMD_READ        = 2'd1;
    localparam logic [1:0] CMD_BURST_READ  = 2'd2;
    localparam logic [1:0] CMD_BURST_WRITE = 2'd3;

    // Frames of a burst write
    localparam logic [1:0] SEG_PROTECT_OFF = 2'd0;
    localparam logic [1:0] SEG_DATA        = 2'd1;
    localparam logic [1:0] SEG_PROTECT_ON  = 2'd2;

    // Command and data bytes on the wire
    localparam logic [7:0] BYTE_WP_ADDR     = 8'h8E;
    localparam logic [7:0] BYTE_WP_OFF      = 8'h00;
    localparam logic [7:0] BYTE_WP_ON       = 8'h80;
    localparam logic [7:0] BYTE_BURST_READ  = 8'hBF;
    localparam logic [7:0] BYTE_BURST_WRITE = 8'hBE;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PREP = 5'b00010,
        PH_LOW  = 5'b00100,
        PH_HIGH = 5'b01000,
        PH_END  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  cmd;
        logic [7:0]  address;
        logic [7:0]  write_byte;
        logic [63:0] burst_data;
        logic        io_in;
    } tick_t;

    typedef struct packed {
        logic        select_pin;
        logic        clock_pin;
        logic        io_out;
        logic        busy_res;
        logic        done_res;
        logic        rejected;
        logic [7:0]  read_byte;
        logic [63:0] burst_result;
    } result_t;

endpackage

// File: src/three_wire_rtc_serial_master_top.sv
// Three-wire RTC serial master: pin sequencer stepped once per accepted tick.
// The result of an accepted tick is registered in the output register.
// Throughput: one tick per cycle; a result held by res_stall holds the input until it leaves.
// The sequencer is a single registered state update per tick.
// Reset: sequencer idle, all latched bytes and read results zero, no result pending.
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_top
    import twrtc_pkg::*;
#(
    parameter int unsigned BURST_BYTES = BURST_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_valid,
    output logic    tick_stall,
    input  tick_t   tick,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    localparam int unsigned BYTES_CL   = (BURST_BYTES < 1) ? 1 :
                                         (BURST_BYTES > 8) ? 8 : BURST_BYTES;
    localparam int unsigned BURST_BITS = BYTES_CL * 8;
    localparam logic [63:0] BURST_MASK = (BURST_BITS >= 64) ? {64{1'b1}} :
                                         ((64'd1 << BURST_BITS) - 64'd1);
    localparam logic [6:0]  SINGLE_TOTAL = 7'd16;
    localparam logic [6:0]  BURST_TOTAL  = 7'(8 + BURST_BITS);

    phase_t      phase_reg,       phase_next;
    logic [6:0]  bit_count_reg,   bit_count_next;
    logic [1:0]  segment_reg,     segment_next;
    logic [1:0]  cmd_reg,         cmd_next;
    logic [63:0] shift_out_reg,   shift_out_next;
    logic [63:0] shift_in_reg,    shift_in_next;
    logic [7:0]  address_reg,     address_next;
    logic [7:0]  byte_reg,        byte_next;
    logic [7:0]  last_read_reg,   last_read_next;
    logic [63:0] last_burst_reg,  last_burst_next;
    logic        res_valid_reg,   res_valid_next;
    result_t     res_reg,         res_next;
    result_t     step_out;
    logic        accept;

    assign tick_stall = res_valid_reg & res_stall;
    assign accept     = tick_valid & ~tick_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        logic        idle;
        logic [1:0]  last_seg;
        logic [7:0]  cb;
        logic [6:0]  total;
        logic        rd;
        logic [63:0] data;
        logic        bitv;
        logic [6:0]  offs;
        logic [7:0]  bc_inc;

        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        segment_next    = segment_reg;
        cmd_next        = cmd_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        address_next    = address_reg;
        byte_next       = byte_reg;
        last_read_next  = last_read_reg;
        last_burst_next = last_burst_reg;

        step_out              = '0;
        step_out.select_pin   = 1'b0;
        step_out.clock_pin    = 1'b1;
        step_out.io_out       = 1'b1;

        idle = (phase_reg != PH_PREP) && (phase_reg != PH_LOW) &&
               (phase_reg != PH_HIGH) && (phase_reg != PH_END);

        if (idle)
        begin
            phase_next = PH_IDLE;
            if (tick.start_req)
            begin
                cmd_next       = tick.cmd;
                address_next   = tick.address;
                byte_next      = tick.write_byte;
                shift_out_next = tick.burst_data;
                shift_in_next  = '0;
                segment_next   = '0;
                bit_count_next = '0;
                phase_next     = PH_PREP;
            end
        end
        else
        begin
            step_out.rejected = tick.start_req;
        end

        last_seg = (cmd_next == CMD_BURST_WRITE) ? SEG_PROTECT_ON : SEG_PROTECT_OFF;
        if (segment_next > last_seg)
        begin
            segment_next = last_seg;
        end

        // Describe the current frame
        rd    = 1'b0;
        total = SINGLE_TOTAL;
        data  = '0;
        cb    = address_next;
        case (cmd_next)
            CMD_READ:
            begin
                rd = 1'b1;
            end
            CMD_BURST_READ:
            begin
                cb    = BYTE_BURST_READ;
                rd    = 1'b1;
                total = BURST_TOTAL;
            end
            CMD_BURST_WRITE:
            begin
                if (segment_next == SEG_PROTECT_OFF)
                begin
                    cb   = BYTE_WP_ADDR;
                    data = {56'd0, BYTE_WP_OFF};
                end
                else if (segment_next == SEG_DATA)
                begin
                    cb    = BYTE_BURST_WRITE;
                    total = BURST_TOTAL;
                    data  = shift_out_next;
                end
                else
                begin
                    cb   = BYTE_WP_ADDR;
                    data = {56'd0, BYTE_WP_ON};
                end
            end
            default:
            begin
                data = {56'd0, byte_next};
            end
        endcase

        offs   = bit_count_next - 7'd8;
        bc_inc = {1'b0, bit_count_next} + 8'd1;
        if (bit_count_next < 7'd8)
        begin
            bitv = cb[bit_count_next[2:0]];
        end
        else if (!rd)
        begin
            bitv = data[offs[5:0]];
        end
        else
        begin
            bitv = 1'b1;
        end

        case (phase_next)
            PH_PREP:
            begin
                step_out.busy_res   = 1'b1;
                step_out.select_pin = 1'b0;
                step_out.clock_pin  = 1'b0;
                bit_count_next      = '0;
                phase_next          = PH_LOW;
            end
            PH_LOW:
            begin
                step_out.busy_res   = 1'b1;
                step_out.select_pin = 1'b1;
                step_out.clock_pin  = 1'b0;
                step_out.io_out     = bitv;
                if (rd && (bit_count_next >= 7'd8) && tick.io_in)
                begin
                    shift_in_next = shift_in_next | (64'd1 << offs[5:0]);
                end
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                step_out.busy_res   = 1'b1;
                step_out.select_pin = 1'b1;
                step_out.clock_pin  = 1'b1;
                step_out.io_out     = bitv;
                if (bc_inc >= {1'b0, total})
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    bit_count_next = bc_inc[6:0];
                    phase_next     = PH_LOW;
                end
            end
            PH_END:
            begin
                step_out.busy_res = 1'b1;
                bit_count_next    = '0;
                if (segment_next >= last_seg)
                begin
                    step_out.done_res = 1'b1;
                    if (cmd_next == CMD_READ)
                    begin
                        last_read_next = shift_in_next[7:0];
                    end
                    else if (cmd_next == CMD_BURST_READ)
                    begin
                        last_burst_next = shift_in_next & BURST_MASK;
                    end
                    segment_next = '0;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    // advance to the next frame of the burst write
                    segment_next = segment_next + 2'd1;
                    phase_next   = PH_PREP;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        step_out.read_byte    = step_out.rejected ? 8'd0 : last_read_next;
        step_out.burst_result = last_burst_next;
    end

    assign res_valid_next = accept | (res_valid_reg & res_stall);
    assign res_next       = accept ? step_out : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            segment_reg    <= '0;
            cmd_reg        <= CMD_WRITE;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            address_reg    <= '0;
            byte_reg       <= '0;
            last_read_reg  <= '0;
            last_burst_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                segment_reg    <= segment_next;
                cmd_reg        <= cmd_next;
                shift_out_reg  <= shift_out_next;
                shift_in_reg   <= shift_in_next;
                address_reg    <= address_next;
                byte_reg       <= byte_next;
                last_read_reg  <= last_read_next;
                last_burst_reg <= last_burst_next;
            end
        end
    end

    // Result payload holds while stalled
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
